### hdl/tfdd_pkg.sv
// ----------------------------------------------------------------------------
// Three-finger drag detector package
// Item kinds, drag modes, event codes, register indexes and field widths
// shared by the detector and its testbench.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tfdd_pkg;

    // Item kinds carried in the input tuser.
    localparam logic [1:0] FUNC_FRAME = 2'd0;
    localparam logic [1:0] FUNC_TAP   = 2'd1;
    localparam logic [1:0] FUNC_TICK  = 2'd2;

    // Drag modes.
    localparam logic [2:0] MODE_IDLE  = 3'd0;
    localparam logic [2:0] MODE_PDRAG = 3'd1;
    localparam logic [2:0] MODE_DRAG  = 3'd2;
    localparam logic [2:0] MODE_AWAIT = 3'd3;
    localparam logic [2:0] MODE_PRES  = 3'd4;

    // Events fed to the mode machine.
    localparam logic [2:0] EV_MOTION   = 3'd0;
    localparam logic [2:0] EV_INC      = 3'd1;
    localparam logic [2:0] EV_DEC      = 3'd2;
    localparam logic [2:0] EV_BUTTON   = 3'd3;
    localparam logic [2:0] EV_TAP      = 3'd4;
    localparam logic [2:0] EV_TIMEOUT  = 3'd5;
    localparam logic [2:0] EV_RTIMEOUT = 3'd6;

    // Configuration register indexes.
    localparam logic [2:0] REG_PRESS_DELAY   = 3'd0;
    localparam logic [2:0] REG_WAIT_FINGERS  = 3'd1;
    localparam logic [2:0] REG_RESUME_WINDOW = 3'd2;
    localparam logic [2:0] REG_UNPIN_DIST    = 3'd3;
    localparam logic [2:0] REG_START_MOVE    = 3'd4;
    localparam logic [2:0] REG_MOVE          = 3'd5;

    // Field widths.
    localparam int CFG_TICK_W = 12;
    localparam int COUNT_W    = 4;
    localparam int MOVE_W     = 32;
    localparam int COORD_W    = 15;
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 8;

    // Configuration reset values.
    localparam logic [CFG_TICK_W-1:0] RST_PRESS_DELAY   = 12'd350;
    localparam logic [CFG_TICK_W-1:0] RST_WAIT_FINGERS  = 12'd50;
    localparam logic [CFG_TICK_W-1:0] RST_RESUME_WINDOW = 12'd720;
    localparam logic [MOVE_W-1:0]     RST_UNPIN_DIST    = 32'd1600;
    localparam logic [MOVE_W-1:0]     RST_START_MOVE    = 32'd676;
    localparam logic [MOVE_W-1:0]     RST_MOVE          = 32'd4;

endpackage

### hdl/three_finger_drag_detector_top.sv
// ----------------------------------------------------------------------------
// Three-finger drag detector
// Recognises a three-finger drag from touchpad frames, taps and time ticks
// and issues primary button press and release pulses.
// ----------------------------------------------------------------------------
// A taken request passes from the input register to the result register. One
// request per cycle while the output is not stalled; the mode machine, both timers
// and the squared-distance unpin test are combinational after the input register.
// Reset (i_rst_n low, synchronous) returns to idle with the timers stopped, the
// pin cleared, both stages empty and the registers at their default values.
`timescale 1ns / 1ps

module three_finger_drag_detector_top
    import tfdd_pkg::*;
#(
    parameter int TIMER_BITS = 12
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [2:0]            i_cfg_index,
    input  logic [MOVE_W-1:0]     i_cfg_data,
    // Input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // tdata: fingers[3:0], button_press[4], max_move_sq[36:5],
    //        centroid_x[51:37], centroid_y[66:52], zeros[71:67]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // tuser: func[1:0]
    input  logic [1:0]            s_axis_tuser,
    // Output stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // tdata: press_pulse[0], release_pulse[1], dragging[2], mode[5:3], zeros[7:6]
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    localparam int LW = (TIMER_BITS > CFG_TICK_W) ? TIMER_BITS : CFG_TICK_W;
    localparam logic [LW-1:0] TMAX = LW'((64'd1 << TIMER_BITS) - 64'd1);

    typedef struct packed {
        logic [2:0]            mode;
        logic [TIMER_BITS-1:0] dtim;
        logic                  drun;
        logic [TIMER_BITS-1:0] rtim;
        logic                  rrun;
        logic                  pinned;
        logic                  pin_new;
        logic [COORD_W-1:0]    px;
        logic [COORD_W-1:0]    py;
        logic                  press;
        logic                  rel;
    } t_st;

    typedef struct packed {
        logic [TIMER_BITS-1:0] ld_press;
        logic [TIMER_BITS-1:0] ld_wait;
        logic [TIMER_BITS-1:0] ld_resume;
        logic [COORD_W-1:0]    cx;
        logic [COORD_W-1:0]    cy;
        logic                  far_old;
        logic                  unpin_zero;
    } t_ctx;

    // Timer load value, saturated to the timer width.
    function automatic logic [TIMER_BITS-1:0] f_load(input logic [CFG_TICK_W-1:0] v);
        logic [LW-1:0] w;
        w = LW'(v);
        if (w > TMAX) begin
            w = TMAX;
        end
        return w[TIMER_BITS-1:0];
    endfunction

    function automatic t_st f_end_drag(input t_st si);
        t_st s;
        s        = si;
        s.pinned = 1'b0;
        s.mode   = MODE_IDLE;
        s.rrun   = 1'b0;
        s.rel    = 1'b1;
        return s;
    endfunction

    // One event applied to the mode machine.
    function automatic t_st f_handle(input t_st si, input logic [2:0] ev,
                                     input logic [COUNT_W-1:0] n, input t_ctx c);
        t_st  s;
        logic cnt_ev;
        logic unpin;
        s      = si;
        cnt_ev = (ev == EV_INC) || (ev == EV_DEC);
        // A pin taken in this same item sits on the current centroid.
        unpin  = !s.pinned || (s.pin_new ? c.unpin_zero : c.far_old);
        unique case (s.mode)
            MODE_IDLE: begin
                if (cnt_ev && n == 4'd3) begin
                    s.mode = MODE_PDRAG;
                    s.dtim = c.ld_press;
                    s.drun = 1'b1;
                end
            end
            MODE_PDRAG: begin
                if (cnt_ev) begin
                    if (n != 4'd3) begin
                        s.mode = MODE_IDLE;
                        s.drun = 1'b0;
                    end
                end else if (ev == EV_MOTION) begin
                    if (n == 4'd3) begin
                        s.mode  = MODE_DRAG;
                        s.press = 1'b1;
                        s.drun  = 1'b0;
                    end
                end else if (ev == EV_TIMEOUT) begin
                    s.mode  = MODE_DRAG;
                    s.press = 1'b1;
                end
            end
            MODE_DRAG: begin
                if (cnt_ev) begin
                    if (n <= 4'd1) begin
                        s.pinned  = 1'b1;
                        s.pin_new = 1'b1;
                        s.px      = c.cx;
                        s.py      = c.cy;
                        s.rtim    = c.ld_resume;
                        s.rrun    = 1'b1;
                        s.mode    = MODE_AWAIT;
                    end
                end else if (ev == EV_BUTTON) begin
                    s = f_end_drag(s);
                end
            end
            MODE_AWAIT: begin
                if (ev == EV_INC) begin
                    if (n >= 4'd1 && n <= 4'd3) begin
                        s.pinned  = 1'b1;
                        s.pin_new = 1'b1;
                        s.px      = c.cx;
                        s.py      = c.cy;
                        s.dtim    = c.ld_wait;
                        s.drun    = 1'b1;
                        s.mode    = MODE_PRES;
                    end else if (n > 4'd3) begin
                        s = f_end_drag(s);
                    end
                end else if (ev == EV_MOTION) begin
                    if ((n == 4'd1 || n == 4'd2) && unpin) begin
                        s = f_end_drag(s);
                    end
                end else if (ev == EV_RTIMEOUT || ev == EV_TAP || ev == EV_BUTTON) begin
                    s = f_end_drag(s);
                end
            end
            MODE_PRES: begin
                if (ev == EV_INC) begin
                    if (n > 4'd3) begin
                        s.drun = 1'b0;
                        s      = f_end_drag(s);
                    end
                end else if (ev == EV_MOTION) begin
                    if (n == 4'd3) begin
                        s.pinned = 1'b0;
                        s.rrun   = 1'b0;
                        s.drun   = 1'b0;
                        s.mode   = MODE_DRAG;
                    end
                end else if (ev == EV_RTIMEOUT) begin
                    s.pinned = 1'b0;
                    s.drun   = 1'b0;
                    if (n == 4'd3) begin
                        s.mode = MODE_DRAG;
                    end else begin
                        s.mode = MODE_IDLE;
                        s.rel  = 1'b1;
                    end
                end else if (ev == EV_DEC || ev == EV_TIMEOUT) begin
                    if (ev == EV_DEC) begin
                        s.drun = 1'b0;
                    end
                    if (n <= 4'd2) begin
                        s.mode = MODE_AWAIT;
                    end else if (n == 4'd3) begin
                        s.pinned = 1'b0;
                        s.rrun   = 1'b0;
                        s.mode   = MODE_DRAG;
                    end else begin
                        s = f_end_drag(s);
                    end
                end else begin
                    s.drun = 1'b0;
                    s      = f_end_drag(s);
                end
            end
            default: begin
            end
        endcase
        return s;
    endfunction

    // Configuration registers
    logic [CFG_TICK_W-1:0] r_press_delay, r_wait_fingers, r_resume_window;
    logic [MOVE_W-1:0]     r_unpin_dist, r_start_move, r_move;

    // Input register
    logic                 r_in_valid;
    logic [1:0]           r_func;
    logic [COUNT_W-1:0]   r_count;
    logic                 r_button;
    logic [MOVE_W-1:0]    r_mv;
    logic [COORD_W-1:0]   r_cx, r_cy;

    // Recogniser state
    logic [2:0]            r_mode;
    logic [COUNT_W-1:0]    r_last;
    logic [TIMER_BITS-1:0] r_dtim, r_rtim;
    logic                  r_drun, r_rrun, r_pinned;
    logic [COORD_W-1:0]    r_px, r_py;

    // Result register
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    logic out_free, adv;
    logic [COORD_W-1:0]    adx, ady;
    logic [2*COORD_W-1:0]  sqx, sqy;
    logic [2*COORD_W:0]    dsum;
    t_ctx ctx;
    t_st  cur, n_st;
    logic [COUNT_W-1:0]    n_last;
    logic [MOVE_W-1:0]     thr;
    logic                  fire;

    assign o_cfg_ready   = 1'b1;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign adv           = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || out_free;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_press_delay   <= RST_PRESS_DELAY;
            r_wait_fingers  <= RST_WAIT_FINGERS;
            r_resume_window <= RST_RESUME_WINDOW;
            r_unpin_dist    <= RST_UNPIN_DIST;
            r_start_move    <= RST_START_MOVE;
            r_move          <= RST_MOVE;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_PRESS_DELAY:   r_press_delay   <= i_cfg_data[CFG_TICK_W-1:0];
                REG_WAIT_FINGERS:  r_wait_fingers  <= i_cfg_data[CFG_TICK_W-1:0];
                REG_RESUME_WINDOW: r_resume_window <= i_cfg_data[CFG_TICK_W-1:0];
                REG_UNPIN_DIST:    r_unpin_dist    <= i_cfg_data;
                REG_START_MOVE:    r_start_move    <= i_cfg_data;
                REG_MOVE:          r_move          <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Input register: takes a request whenever the stage is empty or moving on.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_func   <= s_axis_tuser;
            r_count  <= s_axis_tdata[3:0];
            r_button <= s_axis_tdata[4];
            r_mv     <= s_axis_tdata[36:5];
            r_cx     <= s_axis_tdata[51:37];
            r_cy     <= s_axis_tdata[66:52];
        end
    end

    // Squared distance of the centroid from the stored pin point.
    always_comb begin
        adx  = (r_cx >= r_px) ? (r_cx - r_px) : (r_px - r_cx);
        ady  = (r_cy >= r_py) ? (r_cy - r_py) : (r_py - r_cy);
        sqx  = adx * adx;
        sqy  = ady * ady;
        dsum = {1'b0, sqx} + {1'b0, sqy};
    end

    always_comb begin
        ctx.ld_press   = f_load(r_press_delay);
        ctx.ld_wait    = f_load(r_wait_fingers);
        ctx.ld_resume  = f_load(r_resume_window);
        ctx.cx         = r_cx;
        ctx.cy         = r_cy;
        ctx.far_old    = {1'b0, dsum} >= r_unpin_dist;
        ctx.unpin_zero = (r_unpin_dist == '0);
    end

    // Mode machine: the item's events applied in their fixed order.
    always_comb begin
        cur.mode    = r_mode;
        cur.dtim    = r_dtim;
        cur.drun    = r_drun;
        cur.rtim    = r_rtim;
        cur.rrun    = r_rrun;
        cur.pinned  = r_pinned;
        cur.pin_new = 1'b0;
        cur.px      = r_px;
        cur.py      = r_py;
        cur.press   = 1'b0;
        cur.rel     = 1'b0;
        n_st        = cur;
        n_last      = r_last;
        thr         = r_move;
        fire        = 1'b0;
        case (r_func)
            FUNC_FRAME: begin
                if (r_count < r_last) begin
                    n_st = f_handle(n_st, EV_DEC, r_count, ctx);
                end else if (r_count > r_last) begin
                    n_st = f_handle(n_st, EV_INC, r_count, ctx);
                end
                if (r_button) begin
                    n_st = f_handle(n_st, EV_BUTTON, r_count, ctx);
                end
                thr = (n_st.mode == MODE_PDRAG) ? r_start_move : r_move;
                if (r_mv > thr) begin
                    n_st = f_handle(n_st, EV_MOTION, r_count, ctx);
                end
                n_last = r_count;
            end
            FUNC_TAP: begin
                if (n_st.mode == MODE_AWAIT || n_st.mode == MODE_PRES) begin
                    n_st = f_handle(n_st, EV_TAP, r_last, ctx);
                end
            end
            FUNC_TICK: begin
                // Delay timer first, then the resume timer.
                fire = n_st.drun && (n_st.dtim <= TIMER_BITS'(1));
                if (n_st.drun) begin
                    if (fire) begin
                        n_st.dtim = '0;
                        n_st.drun = 1'b0;
                    end else begin
                        n_st.dtim = n_st.dtim - TIMER_BITS'(1);
                    end
                end
                if (fire) begin
                    n_st = f_handle(n_st, EV_TIMEOUT, r_last, ctx);
                end
                fire = n_st.rrun && (n_st.rtim <= TIMER_BITS'(1));
                if (n_st.rrun) begin
                    if (fire) begin
                        n_st.rtim = '0;
                        n_st.rrun = 1'b0;
                    end else begin
                        n_st.rtim = n_st.rtim - TIMER_BITS'(1);
                    end
                end
                if (fire) begin
                    n_st = f_handle(n_st, EV_RTIMEOUT, r_last, ctx);
                end
            end
            default: begin
            end
        endcase
    end

    // State update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_IDLE;
            r_last   <= '0;
            r_dtim   <= '0;
            r_drun   <= 1'b0;
            r_rtim   <= '0;
            r_rrun   <= 1'b0;
            r_pinned <= 1'b0;
            r_px     <= '0;
            r_py     <= '0;
        end else if (adv) begin
            r_mode   <= n_st.mode;
            r_last   <= n_last;
            r_dtim   <= n_st.dtim;
            r_drun   <= n_st.drun;
            r_rtim   <= n_st.rtim;
            r_rrun   <= n_st.rrun;
            r_pinned <= n_st.pinned;
            r_px     <= n_st.px;
            r_py     <= n_st.py;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_data <= {2'b00, n_st.mode,
                           (n_st.mode == MODE_DRAG) || (n_st.mode == MODE_AWAIT)
                               || (n_st.mode == MODE_PRES),
                           n_st.rel, n_st.press};
        end
    end

    // A press always leaves the block dragging.
    a_press_drags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data[0]) |-> r_out_data[2])
        else $error("press pulse without drag");

    // The pin is only held while waiting to resume.
    a_pin_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pinned |-> (r_mode == MODE_AWAIT || r_mode == MODE_PRES))
        else $error("pin held outside resume wait");

    // The delay timer only runs in possible drag or possible resume.
    a_delay_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_drun |-> (r_mode == MODE_PDRAG || r_mode == MODE_PRES))
        else $error("delay timer running in wrong mode");

    // A stalled result holds the recogniser state still.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |=> ($stable(r_mode) && $stable(r_last)))
        else $error("state moved while result stalled");

endmodule

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// Three-finger drag detector testbench
// Feeds touchpad frames, taps, time ticks and unknown item kinds through the
// input stream, predicts the mode, the drag flag and the press and release
// pulses for every request, and checks each result in order. The run goes
// through several register settings, extremes among them, with random gaps
// on both streams and one long output stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import tfdd_pkg::*;

    // Item kind that the detector must ignore.
    localparam logic [1:0] FUNC_ODD = 2'd3;
    // Register indexes beyond the last register.
    localparam logic [2:0] REG_SPARE_6 = 3'd6;
    localparam logic [2:0] REG_SPARE_7 = 3'd7;

    localparam int HOLD_AT     = 150;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 4;

    typedef struct packed {
        logic [1:0]         func;
        logic [COUNT_W-1:0] count;
        logic               button;
        logic [MOVE_W-1:0]  move;
        logic [COORD_W-1:0] cx;
        logic [COORD_W-1:0] cy;
    } t_touch_item;

    typedef struct packed {
        logic       press_pulse;
        logic       rel_pulse;
        logic       dragging;
        logic [2:0] mode;
    } t_drag_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [2:0]            i_cfg_index = '0;
    logic [MOVE_W-1:0]     i_cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [1:0]            s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    three_finger_drag_detector_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Stimulus and expectations.
    t_touch_item  pending_items[$];
    t_drag_result awaited_results[$];
    t_touch_item  on_offer;
    t_drag_result want;
    int           n_queued = 0;
    int           n_taken = 0;
    int           n_results = 0;
    int           n_errors = 0;
    int           n_presses = 0;
    int           n_releases = 0;
    logic [7:0]   modes_seen = '0;
    logic         calm = 1'b0;
    int           hold_left = 0;
    logic         hold_done = 1'b0;

    // Shadow of the detector's registers and state.
    logic [CFG_TICK_W-1:0] cfg_press_delay  = RST_PRESS_DELAY;
    logic [CFG_TICK_W-1:0] cfg_wait_fingers = RST_WAIT_FINGERS;
    logic [CFG_TICK_W-1:0] cfg_resume       = RST_RESUME_WINDOW;
    logic [MOVE_W-1:0]     cfg_unpin        = RST_UNPIN_DIST;
    logic [MOVE_W-1:0]     cfg_start_move   = RST_START_MOVE;
    logic [MOVE_W-1:0]     cfg_move         = RST_MOVE;

    logic [2:0]            cur_mode   = MODE_IDLE;
    logic [COUNT_W-1:0]    prev_count = '0;
    logic [CFG_TICK_W-1:0] dly_t      = '0;
    logic                  dly_on     = 1'b0;
    logic [CFG_TICK_W-1:0] rsm_t      = '0;
    logic                  rsm_on     = 1'b0;
    logic                  pinned     = 1'b0;
    logic [COORD_W-1:0]    pin_px     = '0;
    logic [COORD_W-1:0]    pin_py     = '0;
    logic [COORD_W-1:0]    cur_cx     = '0;
    logic [COORD_W-1:0]    cur_cy     = '0;
    logic                  p_press    = 1'b0;
    logic                  p_rel      = 1'b0;

    function automatic void end_drag();
        pinned   = 1'b0;
        cur_mode = MODE_IDLE;
        rsm_on   = 1'b0;
        p_rel    = 1'b1;
    endfunction

    function automatic void pin_here();
        pinned = 1'b1;
        pin_px = cur_cx;
        pin_py = cur_cy;
    endfunction

    function automatic void load_delay(logic [CFG_TICK_W-1:0] ticks);
        dly_t  = ticks;
        dly_on = 1'b1;
    endfunction

    // One event through the mode machine; n is the finger count it sees.
    function automatic void on_event(logic [2:0] ev, logic [COUNT_W-1:0] n);
        longint dx;
        longint dy;
        case (cur_mode)
            MODE_IDLE: begin
                if ((ev == EV_INC || ev == EV_DEC) && n == 3) begin
                    cur_mode = MODE_PDRAG;
                    load_delay(cfg_press_delay);
                end
            end
            MODE_PDRAG: begin
                if (ev == EV_INC || ev == EV_DEC) begin
                    if (n != 3) begin
                        cur_mode = MODE_IDLE;
                        dly_on   = 1'b0;
                    end
                end else if (ev == EV_MOTION) begin
                    if (n == 3) begin
                        cur_mode = MODE_DRAG;
                        p_press  = 1'b1;
                        dly_on   = 1'b0;
                    end
                end else if (ev == EV_TIMEOUT) begin
                    cur_mode = MODE_DRAG;
                    p_press  = 1'b1;
                end
            end
            MODE_DRAG: begin
                if (ev == EV_INC || ev == EV_DEC) begin
                    if (n <= 1) begin
                        pin_here();
                        rsm_t    = cfg_resume;
                        rsm_on   = 1'b1;
                        cur_mode = MODE_AWAIT;
                    end
                end else if (ev == EV_BUTTON) begin
                    end_drag();
                end
            end
            MODE_AWAIT: begin
                if (ev == EV_INC) begin
                    if (n >= 1 && n <= 3) begin
                        pin_here();
                        load_delay(cfg_wait_fingers);
                        cur_mode = MODE_PRES;
                    end else if (n > 3) begin
                        end_drag();
                    end
                end else if (ev == EV_MOTION) begin
                    // Travel from the pin point is measured exactly.
                    dx = longint'(cur_cx) - longint'(pin_px);
                    dy = longint'(cur_cy) - longint'(pin_py);
                    if ((n == 1 || n == 2) &&
                        (!pinned || dx * dx + dy * dy >= longint'(cfg_unpin))) begin
                        end_drag();
                    end
                end else if (ev == EV_RTIMEOUT || ev == EV_TAP || ev == EV_BUTTON) begin
                    end_drag();
                end
            end
            MODE_PRES: begin
                if (ev == EV_INC) begin
                    if (n > 3) begin
                        dly_on = 1'b0;
                        end_drag();
                    end
                end else if (ev == EV_MOTION) begin
                    if (n == 3) begin
                        pinned   = 1'b0;
                        rsm_on   = 1'b0;
                        dly_on   = 1'b0;
                        cur_mode = MODE_DRAG;
                    end
                end else if (ev == EV_RTIMEOUT) begin
                    pinned = 1'b0;
                    dly_on = 1'b0;
                    if (n == 3) begin
                        cur_mode = MODE_DRAG;
                    end else begin
                        cur_mode = MODE_IDLE;
                        p_rel    = 1'b1;
                    end
                end else if (ev == EV_DEC || ev == EV_TIMEOUT) begin
                    if (ev == EV_DEC) dly_on = 1'b0;
                    if (n <= 2) begin
                        cur_mode = MODE_AWAIT;
                    end else if (n == 3) begin
                        pinned   = 1'b0;
                        rsm_on   = 1'b0;
                        cur_mode = MODE_DRAG;
                    end else begin
                        end_drag();
                    end
                end else begin
                    // Button or tap while waiting for the fingers to settle.
                    dly_on = 1'b0;
                    end_drag();
                end
            end
            default: ;
        endcase
    endfunction

    // Expected result of one accepted request.
    function automatic t_drag_result predict_item(t_touch_item it);
        t_drag_result r;
        logic [MOVE_W-1:0] thr;
        p_press = 1'b0;
        p_rel   = 1'b0;
        case (it.func)
            FUNC_FRAME: begin
                cur_cx = it.cx;
                cur_cy = it.cy;
                if (it.count < prev_count) on_event(EV_DEC, it.count);
                else if (it.count > prev_count) on_event(EV_INC, it.count);
                if (it.button) on_event(EV_BUTTON, it.count);
                thr = (cur_mode == MODE_PDRAG) ? cfg_start_move : cfg_move;
                if (it.move > thr) on_event(EV_MOTION, it.count);
                prev_count = it.count;
            end
            FUNC_TAP: begin
                if (cur_mode == MODE_AWAIT || cur_mode == MODE_PRES)
                    on_event(EV_TAP, prev_count);
            end
            FUNC_TICK: begin
                // The delay timer is served before the resume timer.
                if (dly_on) begin
                    if (dly_t <= 1) begin
                        dly_t  = '0;
                        dly_on = 1'b0;
                        on_event(EV_TIMEOUT, prev_count);
                    end else begin
                        dly_t = dly_t - 1'b1;
                    end
                end
                if (rsm_on) begin
                    if (rsm_t <= 1) begin
                        rsm_t  = '0;
                        rsm_on = 1'b0;
                        on_event(EV_RTIMEOUT, prev_count);
                    end else begin
                        rsm_t = rsm_t - 1'b1;
                    end
                end
            end
            default: ;
        endcase
        r.press_pulse = p_press;
        r.rel_pulse   = p_rel;
        r.dragging    = (cur_mode == MODE_DRAG || cur_mode == MODE_AWAIT ||
                         cur_mode == MODE_PRES);
        r.mode        = cur_mode;
        return r;
    endfunction

    task automatic flag_mismatch(string what, int got, int exp_val);
        $display("MISMATCH %s at result %0d: got %0d, expected %0d",
                 what, n_results, got, exp_val);
        n_errors++;
    endtask

    // Input driver: offers queued requests with random gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                awaited_results.push_back(predict_item(on_offer));
                n_taken++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_items.size() != 0 && (calm || $urandom_range(0, 99) >= 14)) begin
                    on_offer = pending_items.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {5'b0, on_offer.cy, on_offer.cx, on_offer.move,
                                      on_offer.button, on_offer.count};
                    s_axis_tuser  <= on_offer.func;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Long output stall, started once the run is well under way.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && n_taken >= HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Output monitor: checks every result against the oldest expectation.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (awaited_results.size() == 0) begin
                    flag_mismatch("result with nothing awaited", int'(m_axis_tdata), 0);
                end else begin
                    want = awaited_results.pop_front();
                    if (m_axis_tdata[0] !== want.press_pulse)
                        flag_mismatch("press_pulse", int'(m_axis_tdata[0]),
                                      int'(want.press_pulse));
                    if (m_axis_tdata[1] !== want.rel_pulse)
                        flag_mismatch("release_pulse", int'(m_axis_tdata[1]),
                                      int'(want.rel_pulse));
                    if (m_axis_tdata[2] !== want.dragging)
                        flag_mismatch("dragging", int'(m_axis_tdata[2]),
                                      int'(want.dragging));
                    if (m_axis_tdata[5:3] !== want.mode)
                        flag_mismatch("mode", int'(m_axis_tdata[5:3]), int'(want.mode));
                    n_presses  += int'(want.press_pulse);
                    n_releases += int'(want.rel_pulse);
                    modes_seen[want.mode] = 1'b1;
                end
                n_results++;
            end
            m_axis_tready <= (hold_left == 0) && (calm || $urandom_range(0, 99) >= 14);
        end
    end

    task automatic add_item(logic [1:0] func, logic [COUNT_W-1:0] n, logic btn,
                            logic [MOVE_W-1:0] mv, logic [COORD_W-1:0] x,
                            logic [COORD_W-1:0] y);
        t_touch_item it;
        it = '{func: func, count: n, button: btn, move: mv, cx: x, cy: y};
        pending_items.push_back(it);
        n_queued++;
    endtask

    // Taps, ticks and odd kinds carry random content in the unused fields.
    task automatic add_bare(logic [1:0] func);
        add_item(func, COUNT_W'($urandom), 1'($urandom), $urandom,
                 COORD_W'($urandom), COORD_W'($urandom));
    endtask

    function automatic logic [COORD_W-1:0] near(logic [COORD_W-1:0] c, int spread);
        int v;
        v = int'(c) + int'($urandom_range(0, 2 * spread)) - spread;
        if (v < 0) v = 0;
        if (v > 32767) v = 32767;
        return v[COORD_W-1:0];
    endfunction

    function automatic logic [MOVE_W-1:0] pick_move();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return $urandom_range(0, 8);
            2: return $urandom_range(0, 1200);
            3: return $urandom;
            4: return '1;
            default: return $urandom_range(0, 40);
        endcase
    endfunction

    function automatic logic rare_button();
        return $urandom_range(0, 99) < 6;
    endfunction

    // A touch-down, a hold or drag, a lift and perhaps a resume, then an end.
    task automatic queue_gesture();
        logic [COORD_W-1:0] bx;
        logic [COORD_W-1:0] by;
        bx = COORD_W'($urandom_range(0, 32767));
        by = COORD_W'($urandom_range(0, 32767));
        add_item(FUNC_FRAME, 3, 1'b0, $urandom_range(0, 3), bx, by);
        repeat ($urandom_range(0, 5)) begin
            if ($urandom_range(0, 1)) add_bare(FUNC_TICK);
            else add_item(FUNC_FRAME, 3, rare_button(), pick_move(), near(bx, 5), near(by, 5));
        end
        add_item(FUNC_FRAME, COUNT_W'($urandom_range(0, 1)), rare_button(), pick_move(),
                 bx, by);
        repeat ($urandom_range(0, 5)) begin
            case ($urandom_range(0, 2))
                0: add_bare(FUNC_TICK);
                1: add_item(FUNC_FRAME, COUNT_W'($urandom_range(1, 2)), rare_button(),
                            pick_move(), near(bx, 60), near(by, 60));
                default: add_item(FUNC_FRAME, 0, 1'b0, pick_move(), 0, 0);
            endcase
        end
        if ($urandom_range(0, 2) != 0) begin
            add_item(FUNC_FRAME, COUNT_W'($urandom_range(1, 3)), rare_button(), pick_move(),
                     near(bx, 10), near(by, 10));
            repeat ($urandom_range(0, 4)) begin
                if ($urandom_range(0, 1)) add_bare(FUNC_TICK);
                else add_item(FUNC_FRAME, COUNT_W'($urandom_range(2, 3)), rare_button(),
                              pick_move(), near(bx, 30), near(by, 30));
            end
        end
        case ($urandom_range(0, 5))
            0: add_bare(FUNC_TAP);
            1: add_item(FUNC_FRAME, COUNT_W'($urandom_range(0, 3)), 1'b1, pick_move(),
                        bx, by);
            2: add_item(FUNC_FRAME, COUNT_W'($urandom_range(4, 15)), 1'b0, pick_move(),
                        bx, by);
            3: add_item(FUNC_FRAME, 0, 1'b0, 0, 0, 0);
            default: repeat ($urandom_range(0, 6)) add_bare(FUNC_TICK);
        endcase
    endtask

    // Mostly gestures, the rest fully random requests of any kind.
    task automatic queue_random(int count);
        int stop_at;
        stop_at = n_queued + count;
        while (n_queued < stop_at) begin
            if ($urandom_range(0, 99) < 80) queue_gesture();
            else add_item(2'($urandom_range(0, 3)), COUNT_W'($urandom), 1'($urandom),
                          $urandom, COORD_W'($urandom), COORD_W'($urandom));
        end
    endtask

    task automatic write_reg(logic [2:0] idx, logic [MOVE_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_PRESS_DELAY:   cfg_press_delay  = data[CFG_TICK_W-1:0];
            REG_WAIT_FINGERS:  cfg_wait_fingers = data[CFG_TICK_W-1:0];
            REG_RESUME_WINDOW: cfg_resume       = data[CFG_TICK_W-1:0];
            REG_UNPIN_DIST:    cfg_unpin        = data;
            REG_START_MOVE:    cfg_start_move   = data;
            REG_MOVE:          cfg_move         = data;
            default: ;
        endcase
    endtask

    task automatic set_all(logic [MOVE_W-1:0] press, logic [MOVE_W-1:0] settle_t,
                           logic [MOVE_W-1:0] resume, logic [MOVE_W-1:0] unpin,
                           logic [MOVE_W-1:0] start_mv, logic [MOVE_W-1:0] mv);
        write_reg(REG_PRESS_DELAY, press);
        write_reg(REG_WAIT_FINGERS, settle_t);
        write_reg(REG_RESUME_WINDOW, resume);
        write_reg(REG_UNPIN_DIST, unpin);
        write_reg(REG_START_MOVE, start_mv);
        write_reg(REG_MOVE, mv);
    endtask

    task automatic set_moderate();
        set_all($urandom_range(1, 6), $urandom_range(0, 4), $urandom_range(2, 12),
                $urandom_range(0, 3000), $urandom_range(0, 1500), $urandom_range(0, 30));
    endtask

    // Waits until every request is taken and every result has come back.
    task automatic settle();
        do @(posedge i_clk);
        while (pending_items.size() != 0 || s_axis_tvalid || awaited_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part with short timers.
        set_all(2, 0, 3, 100, 50, 4);
        write_reg(REG_SPARE_6, '1);
        add_item(FUNC_FRAME, 0, 1'b0, 0, 0, 0);
        add_item(FUNC_ODD, 4'hF, 1'b1, '1, 15'h7FFF, 15'h7FFF);
        add_bare(FUNC_TAP);                                    // tap while idle
        add_item(FUNC_FRAME, 3, 1'b0, 0, 100, 100);            // possible drag
        add_bare(FUNC_TICK);
        add_bare(FUNC_TICK);                                   // press on timeout
        add_item(FUNC_FRAME, 3, 1'b1, 0, 100, 100);            // button ends the drag
        add_item(FUNC_FRAME, 2, 1'b0, 0, 100, 100);
        add_item(FUNC_FRAME, 3, 1'b0, '1, 100, 100);           // press on motion
        add_item(FUNC_FRAME, 1, 1'b0, 0, 100, 100);            // lift: pinned wait
        add_item(FUNC_FRAME, 1, 1'b0, 10, 105, 100);           // travel below the limit
        add_bare(FUNC_TICK);
        add_bare(FUNC_TICK);
        add_item(FUNC_FRAME, 2, 1'b0, 0, 105, 100);            // resume with zero delay
        add_bare(FUNC_TICK);                                   // both timers fire
        add_item(FUNC_FRAME, 3, 1'b0, 0, 200, 300);
        add_item(FUNC_FRAME, 3, 1'b0, 51, 200, 300);
        add_item(FUNC_FRAME, 0, 1'b0, 0, 0, 0);
        add_bare(FUNC_TAP);                                    // tap ends the wait
        add_item(FUNC_FRAME, 15, 1'b1, '1, 15'h7FFF, 15'h7FFF);
        add_item(FUNC_FRAME, 3, 1'b0, 0, 1000, 1000);
        add_item(FUNC_FRAME, 3, 1'b0, 51, 1000, 1000);
        add_item(FUNC_FRAME, 1, 1'b0, 0, 1000, 1000);
        add_item(FUNC_FRAME, 1, 1'b0, 5, 1010, 1000);          // travel reaches the limit
        settle();

        // Random part across several register settings.
        set_moderate();
        queue_random(100);
        settle();

        set_all('1, 32'h0000_0FFF, 32'hFFFF_F001, '1, '1, 0);
        write_reg(REG_SPARE_7, 0);
        queue_random(40);
        settle();

        calm <= 1'b1;
        set_moderate();
        queue_random(90);
        settle();
        calm <= 1'b0;

        set_all(32'h0000_1000, 1, 32'hFFFF_FFFF, 0, 0, '1);
        queue_random(40);
        settle();

        set_moderate();
        queue_random(100);
        settle();

        $display("Covered %0d requests under six register settings, %0d results checked.",
                 n_taken, n_results);
        $display("Saw %0d presses and %0d releases; modes reached (one bit each): %b.",
                 n_presses, n_releases, modes_seen[4:0]);
        if (n_errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #2_000_000;
        $display("Timed out with %0d results still awaited.", awaited_results.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule

### filelist.f
hdl/tfdd_pkg.sv
hdl/three_finger_drag_detector_top.sv
tb/sv/tb_top.sv
